// ===== sv/cclk_pkg.sv =====
`timescale 1ns / 1ps

package cclk_pkg;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [15:0] YEAR_RESET    = 16'd1970;
   localparam logic [31:0] US_PER_SECOND = 32'd1000000;
   // 2^32 - 1e6: above this a tick can wrap the microsecond accumulator
   localparam logic [31:0] WRAP_EDGE     = 32'd4293967296;
   localparam logic [12:0] FRAC_DIV      = 13'd4095;
   localparam logic [44:0] FRAC_HALF     = 45'd2047;
   // floor(2^32 / 15625) and floor(2^18 / 60)
   localparam logic [18:0] RECIP_MEGA    = 19'd274877;
   localparam logic [12:0] RECIP_SIXTY   = 13'd4369;
   // inverses of 25 modulo 2^14 and 2^12 for the divisibility test
   localparam logic [13:0] INV25_14      = 14'd7209;
   localparam logic [11:0] INV25_12      = 12'd3113;
   localparam logic [13:0] LIM25_14      = 14'd655;
   localparam logic [11:0] LIM25_12      = 12'd163;

   typedef struct packed {
      logic        kind;
      logic [31:0] counter_now;
      logic [31:0] cal_period;
      logic [15:0] set_year;
      logic [3:0]  set_month;
      logic [4:0]  set_day;
      logic [4:0]  set_hour;
      logic [5:0]  set_minute;
      logic [5:0]  set_second;
   } req_type;

   typedef struct packed {
      logic [15:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic        running;
   } rsp_type;

   function automatic logic leap_year(input logic [15:0] year);
      logic [27:0] prod_c;
      logic [23:0] prod_q;
      logic        div4;
      logic        by25_c;
      logic        by25_q;
      prod_c = {14'd0, year[15:2]} * {14'd0, INV25_14};
      prod_q = {12'd0, year[15:4]} * {12'd0, INV25_12};
      div4   = (year[1:0] == 2'd0);
      by25_c = (prod_c[13:0] <= LIM25_14);
      by25_q = (prod_q[11:0] <= LIM25_12);
      return (div4 && !by25_c) || ((year[3:0] == 4'd0) && by25_q);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== sv/calibrated_calendar_clock_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  cclk_pkg::req_type
// rsp       out        rsp_valid / rsp_stall  cclk_pkg::rsp_type
//
// One transaction accepted per cycle unless the pipe is full and the output
// stalled; each result passes 11 pipeline registers plus the output register.
// Depth is set by the 1/4095 rounding chain and the two reciprocal divides
// (by 1e6, by 60); the calendar update itself is combinational in the last stage.
// Synchronous active-high reset returns the clock to 1970-01-01 00:00:00.
// A stalled output holds; upstream stages keep filling until the pipe is full.

module calibrated_calendar_clock_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cclk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cclk_pkg::rsp_type rsp_data
);
   import cclk_pkg::*;

   localparam int STAGES = 11;
   localparam int LAST   = STAGES - 1;

   typedef struct packed {
      logic        kind;
      logic        first;
      logic        running;
      logic        leap_set;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } ctl_type;

   typedef struct packed {
      logic        near;
      logic [19:0] k;
      logic [19:0] b;
   } rem_type;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic       hour;
   } split_type;

   // handshake and pipeline control
   logic               en_out;
   logic [STAGES-1:0]  load;
   logic [STAGES-1:0]  valid_ff;
   logic               fire;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   ctl_type            ctl_ff [STAGES];
   ctl_type            ctl_in;

   // tick front end state
   logic               started_ff;
   logic [31:0]        last_counter_ff;

   // stage payloads
   logic [31:0] diff_ff,  diff_in;
   logic [31:0] per_ff;
   logic [31:0] pi_ff,    pi_in;
   logic [43:0] pf_ff,    pf_in;
   logic [31:0] pi2_ff;
   logic [44:0] y_ff,     y_in;
   logic [31:0] part_ff,  part_in;
   logic [33:0] y1_ff,    y1_in;
   logic [22:0] y2;
   logic [31:0] part2_ff, part2_in;
   logic [10:0] h3_ff;
   logic [12:0] y3_ff,    y3_in;
   logic [31:0] us_ff,    us_in;
   logic [31:0] us6_ff;
   logic [44:0] mq_ff,    mq_in;
   logic [12:0] q0_in,    q0_ff;
   logic [31:0] q0x;
   logic [31:0] rdiff;
   logic [31:0] negu;
   logic [20:0] r_ff;
   logic        near_ff,  near_in;
   logic [19:0] k_ff;
   logic        c1;
   logic [20:0] b_full;
   logic [12:0] a_ff,     a_in;
   rem_type     rem_ff,   rem_in;
   logic [24:0] ma_ff,    ma_in;
   logic [12:0] a9_ff;
   rem_type     rem9_ff;
   logic [6:0]  qa;
   logic [12:0] qa60;
   logic [12:0] ra_full;
   logic [6:0]  ra;
   logic        ra_fix;
   logic [6:0]  mm;
   split_type   split_ff, split_in;
   rem_type     rem10_ff;

   // calendar state
   logic [19:0] sub_ff,   sub_in;
   logic [15:0] year_ff,  year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff,   day_in;
   logic [4:0]  hour_ff,  hour_in;
   logic [5:0]  min_ff,   min_in;
   logic [5:0]  sec_ff,   sec_in;
   logic        leap_ff;

   // final-stage terms
   ctl_type     ctl_l;
   logic [20:0] tsum;
   logic        carry;
   logic        wrap;
   logic        advance;
   logic [6:0]  ssum, msum;
   logic [1:0]  cs, cm;
   logic [5:0]  sec_mod, min_mod;
   logic        sec_ovf, min_ovf, hr_ovf;
   logic [5:0]  hsum;
   logic [4:0]  hour_mod;
   logic [5:0]  dnext;
   logic        roll;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !load[0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign fire      = valid_ff[LAST] && en_out;

   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         load[i] = en_out || (|(~valid_ff & ({STAGES{1'b1}} << i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         if (en_out) begin
            rsp_valid_ff <= valid_ff[LAST];
         end
      end
   end

   // accept stage
   always_comb begin
      ctl_in.kind     = req_data.kind;
      ctl_in.first    = (req_data.kind == KIND_TICK) && !started_ff;
      ctl_in.running  = started_ff || (req_data.kind == KIND_TICK);
      ctl_in.leap_set = leap_year(req_data.set_year);
      ctl_in.year     = req_data.set_year;
      ctl_in.month    = req_data.set_month;
      ctl_in.day      = req_data.set_day;
      ctl_in.hour     = req_data.set_hour;
      ctl_in.minute   = req_data.set_minute;
      ctl_in.second   = req_data.set_second;
      diff_in         = req_data.counter_now - last_counter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         last_counter_ff <= '0;
      end else if (req_valid && load[0] && (req_data.kind == KIND_TICK)) begin
         started_ff      <= 1'b1;
         last_counter_ff <= req_data.counter_now;
      end
   end

   // microsecond conversion and decomposition
   always_comb begin
      pi_in    = diff_ff * {12'd0, per_ff[31:12]};
      pf_in    = {12'd0, diff_ff} * {32'd0, per_ff[11:0]};
      y_in     = {1'b0, pf_ff} + FRAC_HALF;
      // y / 4095 = h1 + h2 + h3 + (y3 >= 4095), hN = yN-1 >> 12
      y1_in    = {1'b0, y_ff[44:12]} + {22'd0, y_ff[11:0]};
      part_in  = pi2_ff + y_ff[43:12];
      y2       = {1'b0, y1_ff[33:12]} + {11'd0, y1_ff[11:0]};
      y3_in    = {2'd0, y2[22:12]} + {1'b0, y2[11:0]};
      part2_in = part_ff + {10'd0, y1_ff[33:12]};
      us_in    = part2_ff + {21'd0, h3_ff} + {31'd0, (y3_ff >= FRAC_DIV)};
      mq_in    = {19'd0, us_ff[31:6]} * {26'd0, RECIP_MEGA};
      q0_in    = mq_ff[44:32];
      q0x      = {19'd0, q0_in} * US_PER_SECOND;
      rdiff    = us6_ff - q0x;
      near_in  = us6_ff > WRAP_EDGE;
      negu     = 32'd0 - us6_ff;
      c1       = r_ff >= US_PER_SECOND[20:0];
      a_in     = q0_ff + {12'd0, c1};
      b_full   = c1 ? (r_ff - US_PER_SECOND[20:0]) : r_ff;
      rem_in.near = near_ff;
      rem_in.k    = k_ff;
      rem_in.b    = b_full[19:0];
      ma_in    = {12'd0, a_ff} * {12'd0, RECIP_SIXTY};
      qa       = ma_ff[24:18];
      qa60     = {qa, 6'd0} - {4'd0, qa, 2'd0};
      ra_full  = a9_ff - qa60;
      ra       = ra_full[6:0];
      ra_fix   = ra >= 7'd60;
      mm       = qa + {6'd0, ra_fix};
      split_in.sec  = ra_fix ? 6'(ra - 7'd60) : ra[5:0];
      split_in.hour = mm >= 7'd60;
      split_in.min  = split_in.hour ? 6'(mm - 7'd60) : mm[5:0];
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ctl_ff[0] <= ctl_in;
         diff_ff   <= diff_in;
         per_ff    <= req_data.cal_period;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (load[i]) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
      if (load[1]) begin
         pi_ff <= pi_in;
         pf_ff <= pf_in;
      end
      if (load[2]) begin
         pi2_ff <= pi_ff;
         y_ff   <= y_in;
      end
      if (load[3]) begin
         part_ff <= part_in;
         y1_ff   <= y1_in;
      end
      if (load[4]) begin
         part2_ff <= part2_in;
         h3_ff    <= y2[22:12];
         y3_ff    <= y3_in;
      end
      if (load[5]) begin
         us_ff <= us_in;
      end
      if (load[6]) begin
         us6_ff <= us_ff;
         mq_ff  <= mq_in;
      end
      if (load[7]) begin
         q0_ff   <= q0_in;
         r_ff    <= rdiff[20:0];
         near_ff <= near_in;
         k_ff    <= negu[19:0];
      end
      if (load[8]) begin
         a_ff   <= a_in;
         rem_ff <= rem_in;
      end
      if (load[9]) begin
         ma_ff   <= ma_in;
         a9_ff   <= a_ff;
         rem9_ff <= rem_ff;
      end
      if (load[10]) begin
         split_ff <= split_in;
         rem10_ff <= rem9_ff;
      end
   end

   // calendar update
   always_comb begin
      ctl_l    = ctl_ff[LAST];
      tsum     = {1'b0, sub_ff} + {1'b0, rem10_ff.b};
      carry    = tsum >= US_PER_SECOND[20:0];
      wrap     = rem10_ff.near && (sub_ff >= rem10_ff.k);
      advance  = !wrap && (carry || (split_ff.sec != 6'd0) || (split_ff.min != 6'd0)
                           || split_ff.hour);

      ssum     = {1'b0, sec_ff} + {1'b0, split_ff.sec} + {6'd0, carry};
      cs       = (ssum >= 7'd120) ? 2'd2 : ((ssum >= 7'd60) ? 2'd1 : 2'd0);
      sec_mod  = 6'(ssum - 7'(cs * 7'd60));
      sec_ovf  = (split_ff.min != 6'd0) || split_ff.hour || (ssum >= 7'd60);

      msum     = {1'b0, min_ff} + {1'b0, split_ff.min} + {5'd0, cs};
      cm       = (msum >= 7'd120) ? 2'd2 : ((msum >= 7'd60) ? 2'd1 : 2'd0);
      min_mod  = 6'(msum - 7'(cm * 7'd60));
      min_ovf  = sec_ovf && (split_ff.hour || (msum >= 7'd60));

      hsum     = {1'b0, hour_ff} + {5'd0, split_ff.hour} + {4'd0, cm};
      hour_mod = (hsum >= 6'd24) ? 5'(hsum - 6'd24) : hsum[4:0];
      hr_ovf   = min_ovf && (hsum >= 6'd24);

      dnext    = {1'b0, day_ff} + 6'd1;
      roll     = dnext > {1'b0, month_days(month_ff, leap_ff)};

      sub_in   = sub_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;

      if (ctl_l.kind == KIND_SET) begin
         year_in  = ctl_l.year;
         month_in = ctl_l.month;
         day_in   = ctl_l.day;
         hour_in  = ctl_l.hour;
         min_in   = ctl_l.minute;
         sec_in   = ctl_l.second;
      end else if (!ctl_l.first) begin
         if (wrap) begin
            sub_in = sub_ff - rem10_ff.k;
         end else if (carry) begin
            sub_in = 20'(tsum - US_PER_SECOND[20:0]);
         end else begin
            sub_in = tsum[19:0];
         end
         if (advance) begin
            sec_in = sec_mod;
            if (sec_ovf) begin
               min_in = min_mod;
            end
            if (min_ovf) begin
               hour_in = hour_mod;
            end
            if (hr_ovf) begin
               if (roll) begin
                  day_in = 5'd1;
                  if (month_ff >= MONTH_DEC) begin
                     month_in = MONTH_JAN;
                     year_in  = year_ff + 16'd1;
                  end else begin
                     month_in = month_ff + 4'd1;
                  end
               end else begin
                  day_in = dnext[4:0];
               end
            end
         end
      end

      rsp_data_in.year_out   = year_in;
      rsp_data_in.month_out  = month_in;
      rsp_data_in.day_out    = day_in;
      rsp_data_in.hour_out   = hour_in;
      rsp_data_in.minute_out = min_in;
      rsp_data_in.second_out = sec_in;
      rsp_data_in.running    = ctl_l.running;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         year_ff  <= YEAR_RESET;
         month_ff <= MONTH_JAN;
         day_ff   <= 5'd1;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
      end else if (fire) begin
         sub_ff   <= sub_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
      end
   end

   // leap flag is registered from the year, so it trails it; a rollover lands in January
   always_ff @(posedge clock) begin
      if (reset) begin
         leap_ff <= 1'b0;
      end else if (fire && (ctl_l.kind == KIND_SET)) begin
         leap_ff <= ctl_l.leap_set;
      end else begin
         leap_ff <= leap_year(year_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      sub_ff < US_PER_SECOND[19:0])
      else $error("sub-second accumulator out of range");

   assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("running flag dropped");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LAST] && !en_out) |=> valid_ff[LAST])
      else $error("held transaction lost from last stage");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   import cclk_pkg::*;

   localparam logic [31:0] ONE_US       = 32'h0000_1000;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES = 24;
   localparam int          PHASE_ITEMS  = 185;

   class calendar_checker;
      bit          started;
      bit [31:0]   last_ctr;
      bit [31:0]   sub_us;
      bit [15:0]   year;
      bit [3:0]    month;
      bit [4:0]    day;
      bit [4:0]    hour;
      bit [5:0]    minute;
      bit [5:0]    second;
      rsp_type     pending[$];
      int          faults;

      function new();
         started  = 1'b0;
         last_ctr = '0;
         sub_us   = '0;
         year     = YEAR_RESET;
         month    = MONTH_JAN;
         day      = 5'd1;
         hour     = '0;
         minute   = '0;
         second   = '0;
         faults   = 0;
      endfunction

      function bit is_leap(bit [15:0] y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int unsigned month_len(bit [15:0] y, bit [3:0] m);
         case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            MONTH_FEB: return is_leap(y) ? 29 : 28;
            default: return 31;
         endcase
      endfunction

      // each stage only runs when the one before it overflowed
      function void carry_seconds(bit [31:0] secs);
         bit [63:0] s;
         bit [63:0] mi;
         bit [63:0] h;
         bit [63:0] d;
         s = 64'(second) + 64'(secs);
         second = s[5:0];
         if (s < 60) return;
         mi = 64'(minute) + s / 60;
         second = 6'(s % 60);
         minute = mi[5:0];
         if (mi < 60) return;
         h = 64'(hour) + mi / 60;
         minute = 6'(mi % 60);
         hour = h[4:0];
         if (h < 24) return;
         d = 64'(day) + h / 24;
         hour = 5'(h % 24);
         if (d > 64'(month_len(year, month))) begin
            day = 5'd1;
            if (month >= MONTH_DEC) begin
               month = MONTH_JAN;
               year  = year + 16'd1;
            end else begin
               month = month + 4'd1;
            end
         end else begin
            day = d[4:0];
         end
      endfunction

      function void take_request(req_type t);
         bit [31:0] diff;
         bit [31:0] q;
         bit [63:0] prod;
         bit [63:0] rnd;
         bit [63:0] total;
         rsp_type   want;
         if (t.kind == KIND_SET) begin
            year   = t.set_year;
            month  = t.set_month;
            day    = t.set_day;
            hour   = t.set_hour;
            minute = t.set_minute;
            second = t.set_second;
         end else if (!started) begin
            started  = 1'b1;
            last_ctr = t.counter_now;
         end else begin
            diff  = t.counter_now - last_ctr;
            prod  = 64'(diff) * 64'(t.cal_period[11:0]);
            rnd   = (2 * prod + 64'(FRAC_DIV)) / (2 * 64'(FRAC_DIV));
            total = 64'(diff) * 64'(t.cal_period[31:12]) + rnd;
            last_ctr = t.counter_now;
            sub_us = sub_us + total[31:0];
            if (sub_us >= US_PER_SECOND) begin
               q      = sub_us / US_PER_SECOND;
               sub_us = sub_us % US_PER_SECOND;
               carry_seconds(q);
            end
         end
         want.year_out   = year;
         want.month_out  = month;
         want.day_out    = day;
         want.hour_out   = hour;
         want.minute_out = minute;
         want.second_out = second;
         want.running    = started;
         pending.push_back(want);
      endfunction

      function void log_fault(string msg);
         faults++;
         if (faults <= 10) $display("%s", msg);
      endfunction

      function void check_reading(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            log_fault($sformatf("unexpected reading %0d-%0d-%0d %0d:%0d:%0d run=%0b",
               got.year_out, got.month_out, got.day_out, got.hour_out,
               got.minute_out, got.second_out, got.running));
            return;
         end
         want = pending.pop_front();
         if (got.year_out !== want.year_out || got.month_out !== want.month_out ||
             got.day_out !== want.day_out || got.hour_out !== want.hour_out ||
             got.minute_out !== want.minute_out || got.second_out !== want.second_out ||
             got.running !== want.running) begin
            log_fault($sformatf(
               "reading mismatch: exp %0d-%0d-%0d %0d:%0d:%0d run=%0b, got %0d-%0d-%0d %0d:%0d:%0d run=%0b",
               want.year_out, want.month_out, want.day_out, want.hour_out,
               want.minute_out, want.second_out, want.running,
               got.year_out, got.month_out, got.day_out, got.hour_out,
               got.minute_out, got.second_out, got.running));
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int          idle_pct     = 0;
   int          stall_pct    = 0;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   logic [31:0] ctr_reading  = '0;

   calendar_checker cal = new();

   calibrated_calendar_clock_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) cal.check_reading(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_set(logic [15:0] y, logic [3:0] mo, logic [4:0] d,
                                        logic [4:0] h, logic [5:0] mi, logic [5:0] s);
      req_type t;
      t.kind        = KIND_SET;
      t.counter_now = $urandom;
      t.cal_period  = $urandom;
      t.set_year    = y;
      t.set_month   = mo;
      t.set_day     = d;
      t.set_hour    = h;
      t.set_minute  = mi;
      t.set_second  = s;
      return t;
   endfunction

   function automatic req_type make_tick(logic [31:0] diff, logic [31:0] period);
      req_type t;
      ctr_reading   = ctr_reading + diff;
      t.kind        = KIND_TICK;
      t.counter_now = ctr_reading;
      t.cal_period  = period;
      t.set_year    = $urandom;
      {t.set_month, t.set_day, t.set_hour, t.set_minute, t.set_second} = $urandom;
      return t;
   endfunction

   // mostly near-nominal 1 us counts, sometimes coarse periods and long gaps
   function automatic req_type plausible_tick();
      logic [31:0] diff;
      logic [31:0] period;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: diff = $urandom_range(900_000, 1_100_000);
         5, 6, 7:       diff = $urandom_range(1, 4_000_000);
         default:       diff = $urandom_range(0, 2000);
      endcase
      if ($urandom_range(3) == 0) period = {$urandom_range(0, 3), 12'($urandom)};
      else period = ONE_US + $urandom_range(0, 400) - 200;
      return make_tick(diff, period);
   endfunction

   task automatic send_request(input req_type t);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      cal.take_request(t);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      int          stop_at;
      logic [15:0] y;
      logic [3:0]  mo;
      stop_at   = items_sent + count;
      idle_pct  = idle;
      stall_pct = stall;
      while (items_sent < stop_at) begin
         case ($urandom_range(19))
            0, 1: begin
               ctr_reading = $urandom;
               send_request(make_tick(32'd0, $urandom));
            end
            2, 3: send_request(make_set($urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
            4, 5, 6, 7, 8: repeat ($urandom_range(1, 6)) send_request(plausible_tick());
            default: begin
               case ($urandom_range(7))
                  0:       y = 16'd1900;
                  1:       y = 16'd2000;
                  2:       y = 16'd2023;
                  3:       y = 16'd2024;
                  4:       y = 16'd2100;
                  5:       y = 16'hFFFF;
                  6:       y = 16'd0;
                  default: y = $urandom;
               endcase
               if ($urandom_range(9) == 0) mo = $urandom_range(15);
               else mo = $urandom_range(1, 12);
               send_request(make_set(y, mo, $urandom_range(27, 31), $urandom_range(20, 23),
                                     $urandom_range(50, 59), $urandom_range(0, 59)));
               repeat ($urandom_range(2, 8)) send_request(plausible_tick());
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // loads before the counter is latched, at both extremes
      send_request(make_set(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F));
      send_request(make_set(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
      ctr_reading = 32'hFFFF_FFF0;
      send_request(make_tick(32'd0, $urandom));
      // year end, with the counter wrapping
      send_request(make_set(16'd2023, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      // February in leap, common and century years
      send_request(make_set(16'd2024, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      send_request(make_tick(32'd86_400, 32'hFFFF_F000));
      send_request(make_set(16'd1900, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      send_request(make_set(16'd2000, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      // months outside the calendar, then the largest year rolling over
      send_request(make_set(16'd2023, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      send_request(make_set(16'd2023, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      send_request(make_set(16'hFFFF, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59));
      send_request(make_tick(US_PER_SECOND, ONE_US));
      // out-of-range load then a carry of over an hour
      send_request(make_set(16'd2023, MONTH_APR, 5'd31, 5'd31, 6'd63, 6'd63));
      send_request(make_tick(32'd4_290_000_000, ONE_US));
      // zero period, widest period, fraction only
      send_request(make_tick($urandom, 32'd0));
      send_request(make_tick(32'd5000, 32'hFFFF_FFFF));
      send_request(make_tick(US_PER_SECOND, 32'h0000_0FFF));
      send_request(make_tick(32'd0, 32'hFFFF_FFFF));

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(57, 0, PHASE_ITEMS);
      run_phase(0, 57, PHASE_ITEMS);
      run_phase(8, 8, PHASE_ITEMS);

      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      while (cal.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cal.faults == 0 && cal.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== calibrated_calendar_clock_top.f =====
sv/cclk_pkg.sv
sv/calibrated_calendar_clock_top.sv
dv/tb.sv
